/* rtl/sbha_pkg.sv */
// Shared types and codes for the segregated-bin heap allocator.
`default_nettype none

package sbha_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_BUMPED      = 3'd0;
   localparam logic [2:0] ST_FROM_BIN    = 3'd1;
   localparam logic [2:0] ST_OUT_OF_HEAP = 3'd2;
   localparam logic [2:0] ST_ZERO_SIZE   = 3'd3;
   localparam logic [2:0] ST_BINNED      = 3'd4;
   localparam logic [2:0] ST_DROPPED     = 3'd5;
   localparam logic [2:0] ST_NULL_FREE   = 3'd6;

   localparam logic [16:0] MIN_CHUNK        = 17'd32;
   localparam logic [16:0] HEAP_LIMIT_RESET = 17'h10000;

   typedef struct packed {
      logic        op;
      logic [15:0] request_size;
      logic [15:0] user_address;
   } sbha_req_type;

   typedef struct packed {
      logic [15:0] result_address;
      logic [16:0] chunk_bytes;
      logic [2:0]  status;
   } sbha_rsp_type;

endpackage

`default_nettype wire

/* rtl/segregated_bin_heap_allocator.sv */
// Top level of the segregated-bin heap allocator: control around bin-head and header RAMs.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_ready   sbha_req_type (op, size, address)
//   rsp_     out        rsp_valid / rsp_ready   sbha_rsp_type (address, bytes, status)
//   csr_     in         csr_write_en            heap_limit, 17 bits
//
// One request at a time. Zero size, bump, out of heap, null free and dropped free finish
// in the decide state; a bin pop or push goes on to a pop or push state, as each needs a second
// dependent read of the header or bin-head RAM before the write-back.
// After reset the bin-head RAM is swept to empty, every bin in turn, with req_ready low.
// A result waits in the output register; a full register stalls the final state only.
`default_nettype none

module segregated_bin_heap_allocator #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 16,
   parameter int BIN_LIMIT    = 1024,
   parameter int NUM_BINS     = 62
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire sbha_pkg::sbha_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sbha_pkg::sbha_rsp_type     rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [16:0]           csr_write_data
);

   import sbha_pkg::*;

   // addresses are 16 bits, so no more than 4096 granules are ever reachable
   localparam int GRANULES   = HEAP_BYTES / 16;
   localparam int HDR_DEPTH  = (GRANULES < 4096) ? GRANULES : 4096;
   localparam int GW         = $clog2(HDR_DEPTH);
   localparam int LW         = $clog2(HDR_DEPTH + 1);
   localparam int BW         = $clog2(NUM_BINS);
   localparam int HEAP_CAP_I = (HEAP_BYTES > 131071) ? 131071 : HEAP_BYTES;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_POP    = 3'd3;
   localparam logic [2:0] S_PUSH   = 3'd4;

   localparam logic [BW-1:0] CLR_LAST = BW'(NUM_BINS - 1);

   logic [2:0]    state_ff, state_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [16:0]   heap_limit_ff;
   logic [16:0]   break_ff, break_in;
   logic          rsp_valid_ff;
   sbha_rsp_type  rsp_data_ff;

   logic          op_ff, zero_ff, null_ff, hit_ff;
   logic [16:0]   bytes_ff;
   logic [BW-1:0] bin_ff;
   logic [GW-1:0] gran_ff;
   logic [LW-1:0] size_ff;

   logic          req_accept, out_free;
   logic [16:0]   alloc_bytes;
   logic [BW-1:0] req_bin, hdr_bin;
   logic          req_hit, hdr_hit;
   logic [15:0]   ua_off;
   logic [11:0]   ua_gran;
   logic          ua_null;

   logic          bin_we, bin_re;
   logic [BW-1:0] bin_waddr, bin_raddr;
   logic [LW-1:0] bin_wdata, bin_rdata;
   logic          hdr_we, hdr_re;
   logic [GW-1:0] hdr_waddr, hdr_raddr;
   logic [2*LW-1:0] hdr_wdata, hdr_rdata;

   logic [LW-1:0] hdr_size, hdr_next, head_less;
   logic [GW-1:0] head_gran;
   logic [16:0]   free_bytes;
   logic          pop_go, fits;
   logic [17:0]   limit, break_end;
   logic [15:0]   pop_addr, bump_addr;
   logic [LW-1:0] gran_plus;
   logic          emit;
   sbha_rsp_type  emit_data;

   // request decode
   assign alloc_bytes = (17'(req_data.request_size) + 17'(HEADER_BYTES) + 17'hF) & ~17'hF;
   assign ua_off      = req_data.user_address - 16'(HEADER_BYTES);
   assign ua_gran     = ua_off[15:4];
   assign ua_null     = (req_data.user_address < 16'(HEADER_BYTES))
                        || ({1'b0, ua_gran} >= 13'(HDR_DEPTH));

   sbha_bin #(.BIN_LIMIT(BIN_LIMIT), .NUM_BINS(NUM_BINS), .BW(BW)) u_req_bin (
      .chunk_bytes(alloc_bytes),
      .bin        (req_bin),
      .hit        (req_hit)
   );

   // header word: size in granules above, next link below
   assign hdr_size   = hdr_rdata[2*LW-1:LW];
   assign hdr_next   = hdr_rdata[LW-1:0];
   assign free_bytes = 17'({hdr_size, 4'h0});

   sbha_bin #(.BIN_LIMIT(BIN_LIMIT), .NUM_BINS(NUM_BINS), .BW(BW)) u_hdr_bin (
      .chunk_bytes(free_bytes),
      .bin        (hdr_bin),
      .hit        (hdr_hit)
   );

   assign head_less = bin_rdata - LW'(1);
   assign head_gran = head_less[GW-1:0];
   assign pop_go    = !zero_ff && hit_ff && (bin_rdata != '0);

   assign limit     = (18'(heap_limit_ff) < 18'(HEAP_CAP_I)) ? 18'(heap_limit_ff)
                                                            : 18'(HEAP_CAP_I);
   assign break_end = {1'b0, break_ff} + {1'b0, bytes_ff};
   assign fits      = (break_end <= limit);

   assign pop_addr  = 16'({gran_ff, 4'h0}) + 16'(HEADER_BYTES);
   assign bump_addr = break_ff[15:0] + 16'(HEADER_BYTES);
   assign gran_plus = LW'(gran_ff) + LW'(1);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   assign bin_raddr = (state_ff == S_IDLE) ? req_bin : hdr_bin;
   assign hdr_raddr = (state_ff == S_IDLE) ? ua_gran[GW-1:0] : head_gran;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      break_in  = break_ff;
      emit      = 1'b0;
      emit_data = '0;
      bin_we    = 1'b0;
      bin_waddr = bin_ff;
      bin_wdata = '0;
      bin_re    = 1'b0;
      hdr_we    = 1'b0;
      hdr_waddr = gran_ff;
      hdr_wdata = '0;
      hdr_re    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            bin_we    = 1'b1;
            bin_waddr = clr_ff;
            clr_in    = clr_ff + BW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_DECIDE;
               bin_re   = (req_data.op == OP_ALLOC);
               hdr_re   = (req_data.op == OP_FREE);
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_ALLOC) begin
               if (zero_ff) begin
                  if (out_free) begin
                     emit             = 1'b1;
                     emit_data.status = ST_ZERO_SIZE;
                     state_in         = S_IDLE;
                  end
               end else if (pop_go) begin
                  // fetch the top chunk's link before updating the bin head
                  hdr_re   = 1'b1;
                  state_in = S_POP;
               end else if (out_free) begin
                  emit                  = 1'b1;
                  emit_data.chunk_bytes = bytes_ff;
                  state_in              = S_IDLE;
                  if (fits) begin
                     // drop the header of a chunk that no address can reach
                     hdr_we                   = (break_ff[16:4] < 13'(HDR_DEPTH));
                     hdr_waddr                = break_ff[GW+3:4];
                     hdr_wdata                = {bytes_ff[LW+3:4], LW'(0)};
                     break_in                 = break_end[16:0];
                     emit_data.result_address = bump_addr;
                     emit_data.status         = ST_BUMPED;
                  end else begin
                     emit_data.status = ST_OUT_OF_HEAP;
                  end
               end
            end else begin
               if (null_ff) begin
                  if (out_free) begin
                     emit             = 1'b1;
                     emit_data.status = ST_NULL_FREE;
                     state_in         = S_IDLE;
                  end
               end else if (!hdr_hit) begin
                  if (out_free) begin
                     emit                  = 1'b1;
                     emit_data.chunk_bytes = free_bytes;
                     emit_data.status      = ST_DROPPED;
                     state_in              = S_IDLE;
                  end
               end else begin
                  bin_re   = 1'b1;
                  state_in = S_PUSH;
               end
            end
         end
         S_POP: begin
            if (out_free) begin
               bin_we                   = 1'b1;
               bin_wdata                = hdr_next;
               emit                     = 1'b1;
               emit_data.result_address = pop_addr;
               emit_data.chunk_bytes    = bytes_ff;
               emit_data.status         = ST_FROM_BIN;
               state_in                 = S_IDLE;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               hdr_we                = 1'b1;
               hdr_wdata             = {size_ff, bin_rdata};
               bin_we                = 1'b1;
               bin_wdata             = gran_plus;
               emit                  = 1'b1;
               emit_data.chunk_bytes = bytes_ff;
               emit_data.status      = ST_BINNED;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         heap_limit_ff <= HEAP_LIMIT_RESET;
         break_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         break_ff <= break_in;
         if (csr_write_en) begin
            heap_limit_ff <= csr_write_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
      if (req_accept) begin
         op_ff    <= req_data.op;
         zero_ff  <= (req_data.request_size == 16'h0);
         null_ff  <= ua_null;
         bytes_ff <= alloc_bytes;
         bin_ff   <= req_bin;
         hit_ff   <= req_hit;
         gran_ff  <= ua_gran[GW-1:0];
      end
      if ((state_ff == S_DECIDE) && hdr_re) begin
         gran_ff <= head_gran;
      end
      if ((state_ff == S_DECIDE) && bin_re) begin
         bytes_ff <= free_bytes;
         size_ff  <= hdr_size;
         bin_ff   <= hdr_bin;
      end
   end

   sbha_ram #(.WIDTH(LW), .DEPTH(NUM_BINS)) u_bin_ram (
      .clock  (clock),
      .wr_en  (bin_we),
      .wr_addr(bin_waddr),
      .wr_data(bin_wdata),
      .rd_en  (bin_re),
      .rd_addr(bin_raddr),
      .rd_data(bin_rdata)
   );

   sbha_ram #(.WIDTH(2 * LW), .DEPTH(HDR_DEPTH)) u_hdr_ram (
      .clock  (clock),
      .wr_en  (hdr_we),
      .wr_addr(hdr_waddr),
      .wr_data(hdr_wdata),
      .rd_en  (hdr_re),
      .rd_addr(hdr_raddr),
      .rd_data(hdr_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/sbha_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sbha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/sbha_bin.sv */
// Maps a chunk size in bytes to its exact-size bin, flagging sizes without a bin.
`default_nettype none

module sbha_bin #(
   parameter int BIN_LIMIT = 1024,
   parameter int NUM_BINS  = 62,
   parameter int BW        = 6
) (
   input  wire logic [16:0]   chunk_bytes,
   output logic      [BW-1:0] bin,
   output logic               hit
);

   import sbha_pkg::*;

   logic [16:0] offset;
   logic [12:0] index;

   assign offset = chunk_bytes - MIN_CHUNK;
   assign index  = offset[16:4];
   assign bin    = index[BW-1:0];
   assign hit    = (chunk_bytes >= MIN_CHUNK) && (chunk_bytes < 17'(BIN_LIMIT))
                   && (index < 13'(NUM_BINS));

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the segregated-bin heap allocator: scoreboard, stimulus, checks.
`timescale 1ns / 100ps

module testbench;
   import sbha_pkg::*;

   localparam int HEAP_BYTES     = 65536;
   localparam int HEADER_BYTES   = 16;
   localparam int BIN_LIMIT      = 1024;
   localparam int NUM_BINS       = 62;
   localparam int GRANULES       = HEAP_BYTES / 16;
   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int REPORT_LIMIT   = 10;

   // Mirror of the allocator state, plus the queue of responses still owed.
   class allocator_scoreboard;
      logic [16:0]  heap_limit;
      logic [16:0]  break_pointer;
      logic [12:0]  bin_top [NUM_BINS];
      logic [16:0]  chunk_size [GRANULES];
      logic [12:0]  chunk_link [GRANULES];
      int unsigned  carved [$];
      int unsigned  live [$];
      sbha_rsp_type expected_responses [$];
      int           errors;
      int           checked;

      function new();
         heap_limit    = HEAP_LIMIT_RESET;
         break_pointer = '0;
         errors        = 0;
         checked       = 0;
         foreach (bin_top[b]) bin_top[b] = '0;
         foreach (chunk_size[g]) begin
            chunk_size[g] = '0;
            chunk_link[g] = '0;
         end
      endfunction

      function int unsigned size_class(logic [16:0] bytes);
         int unsigned idx;
         if (bytes < MIN_CHUNK || bytes >= BIN_LIMIT) return NUM_BINS;
         idx = (bytes - MIN_CHUNK) / 16;
         return (idx < NUM_BINS) ? idx : NUM_BINS;
      endfunction

      // Work out the response to one request and advance the mirrored heap.
      function sbha_rsp_type serve_request(sbha_req_type word);
         sbha_rsp_type rsp;
         logic [16:0]  bytes;
         logic [16:0]  limit;
         int unsigned  bin;
         int unsigned  g;
         rsp = '0;
         if (word.op == OP_ALLOC) begin
            if (word.request_size == '0) begin
               rsp.status = ST_ZERO_SIZE;
               return rsp;
            end
            bytes = (17'(word.request_size) + 17'(HEADER_BYTES) + 17'h0F) & ~17'h0F;
            bin = size_class(bytes);
            rsp.chunk_bytes = bytes;
            if (bin < NUM_BINS && bin_top[bin] != '0) begin
               g = bin_top[bin] - 1;
               bin_top[bin] = chunk_link[g];
               rsp.result_address = 16'(g * 16 + HEADER_BYTES);
               rsp.status = ST_FROM_BIN;
               live.push_back(g);
               return rsp;
            end
            limit = (heap_limit < HEAP_BYTES) ? heap_limit : 17'(HEAP_BYTES);
            if (break_pointer > limit || bytes > limit - break_pointer) begin
               rsp.status = ST_OUT_OF_HEAP;
               return rsp;
            end
            g = break_pointer / 16;
            chunk_size[g] = bytes;
            chunk_link[g] = '0;
            carved.push_back(g);
            live.push_back(g);
            rsp.result_address = 16'(break_pointer + HEADER_BYTES);
            rsp.status = ST_BUMPED;
            break_pointer = break_pointer + bytes;
            return rsp;
         end
         if (word.user_address < HEADER_BYTES) begin
            rsp.status = ST_NULL_FREE;
            return rsp;
         end
         // a misaligned address lands on the granule that holds it
         g = (word.user_address - HEADER_BYTES) / 16;
         bytes = chunk_size[g] & ~17'h0F;
         bin = size_class(bytes);
         rsp.chunk_bytes = bytes;
         if (bin >= NUM_BINS) begin
            rsp.status = ST_DROPPED;
            return rsp;
         end
         chunk_link[g] = bin_top[bin];
         bin_top[bin] = 13'(g + 1);
         rsp.status = ST_BINNED;
         return rsp;
      endfunction

      function void note_request(sbha_req_type word);
         expected_responses.push_back(serve_request(word));
      endfunction

      function void check_response(sbha_rsp_type got);
         sbha_rsp_type want;
         checked++;
         if (expected_responses.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("response %0d unexpected: address %h bytes %0d status %0d",
                        checked, got.result_address, got.chunk_bytes, got.status);
            return;
         end
         want = expected_responses.pop_front();
         if (got.result_address !== want.result_address ||
             got.chunk_bytes !== want.chunk_bytes || got.status !== want.status) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("response %0d: expected %h/%0d/%0d got %h/%0d/%0d (address/bytes/status)",
                        checked, want.result_address, want.chunk_bytes, want.status,
                        got.result_address, got.chunk_bytes, got.status);
         end
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   sbha_req_type        req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   sbha_rsp_type        rsp_data;
   logic                csr_write_en;
   logic [16:0]         csr_write_data;

   allocator_scoreboard board;
   int                  send_idle_pct;
   int                  recv_stall_pct;
   int                  holdoffs_asked;
   int                  quiet_cycles;

   segregated_bin_heap_allocator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one word and hold it until the allocator takes it.
   task automatic send_request(input sbha_req_type word);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(word);
   endtask

   // Drop the word already taken, then hold until every owed response is back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_heap_limit(input logic [16:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      board.heap_limit = value;
   endtask

   // Mostly allocate and free carved chunks, live or already binned; the rest is null frees, zero and oversized asks.
   function automatic sbha_req_type next_request();
      sbha_req_type word;
      int unsigned  pick;
      int unsigned  idx;
      int unsigned  g;
      int unsigned  offset;
      word.op           = OP_ALLOC;
      word.request_size = 16'($urandom);
      word.user_address = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 40 && board.carved.size() != 0) begin
         word.op = OP_FREE;
         if (board.live.size() != 0 && $urandom_range(3) != 0) begin
            idx = $urandom_range(board.live.size() - 1);
            g = board.live[idx];
            board.live.delete(idx);
         end else begin
            // may hit a chunk already binned: a repeated free
            g = board.carved[$urandom_range(board.carved.size() - 1)];
         end
         offset = ($urandom_range(2) == 0) ? $urandom_range(15) : 0;
         word.user_address = 16'(g * 16 + HEADER_BYTES + offset);
      end else if (pick < 45) begin
         word.op = OP_FREE;
         word.user_address = 16'($urandom_range(HEADER_BYTES - 1));
      end else if (pick < 48) begin
         word.request_size = '0;
      end else if (pick < 52) begin
         // keep the full-range size
      end else if (pick < 55) begin
         word.request_size = 16'($urandom_range(2032, 993));
      end else if (pick < 65) begin
         word.request_size = 16'($urandom_range(992, 241));
      end else begin
         word.request_size = 16'($urandom_range(240, 1));
      end
      return word;
   endfunction

   task automatic run_phase(input int items, input int send_pct, input int stall_pct);
      sbha_req_type word;
      int           n;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < items; n++) begin
         word = next_request();
         while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         send_request(word);
      end
   endtask

   // Receiver: random stalls, and a long hold-off whenever one is asked for.
   initial begin : receiver
      int served;
      int left;
      served    = 0;
      left      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_asked != served) begin
            served++;
            left = HOLDOFF_CYCLES;
         end
         if (left > 0) begin
            left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      board          = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoffs_asked = 0;
      quiet_cycles   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: edges of size and address, bin reuse, drops and repeated free.
      send_request(sbha_req_type'{OP_ALLOC, 16'd0,     16'hFFFF});
      send_request(sbha_req_type'{OP_FREE,  16'hFFFF,  16'd0});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd15});
      send_request(sbha_req_type'{OP_ALLOC, 16'd1,     16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'd16,    16'hFFFF});
      send_request(sbha_req_type'{OP_ALLOC, 16'd992,   16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'd1008,  16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'hFFFF,  16'd0});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd16});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd63});
      send_request(sbha_req_type'{OP_ALLOC, 16'd10,    16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'd5,     16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'd7,     16'd0});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd1088});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd80});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd95});
      send_request(sbha_req_type'{OP_ALLOC, 16'd992,   16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'd992,   16'd0});
      send_request(sbha_req_type'{OP_ALLOC, 16'd976,   16'd0});
      send_request(sbha_req_type'{OP_FREE,  16'd0,     16'd16});

      wait_for_drain();
      write_heap_limit(17'h1FFFF);
      run_phase(350, 0, 0);

      // no room at all: only bin hits succeed
      wait_for_drain();
      write_heap_limit(17'd0);
      run_phase(100, 82, 0);

      wait_for_drain();
      write_heap_limit(17'($urandom_range(65535, 32768)));
      run_phase(350, 0, 82);

      wait_for_drain();
      write_heap_limit(HEAP_LIMIT_RESET);
      run_phase(300, 26, 26);

      // Back-pressure: hold the receiver off so that the input stalls, then pause until drained.
      holdoffs_asked = holdoffs_asked + 1;
      run_phase(40, 0, 0);
      wait_for_drain();
      run_phase(60, 0, 0);

      wait_for_drain();
      write_heap_limit(17'hFFFF);
      run_phase(200, 26, 26);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
rtl/sbha_pkg.sv
rtl/sbha_ram.sv
rtl/sbha_bin.sv
rtl/segregated_bin_heap_allocator.sv
tb/testbench.sv
